[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on the rising edge and held
// off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

[hdl/mlvm_pkg.sv]
// ----------------------------------------------------------------------------
// mlvm_pkg
// Types, constants and rounding helpers of the mouse-look view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package mlvm_pkg;

	// CORDIC iteration count, at most 24 are used
	localparam int TRIG_STEPS   = 16;
	localparam int CORDIC_STEPS = (TRIG_STEPS > 24) ? 24 : TRIG_STEPS;

	localparam int ANGLE_FULL = 36000;
	localparam int ANGLE_HALF = 18000;
	localparam int ANGLE_QTR  = 9000;
	localparam int PITCH_MAX  = 8999;
	localparam int Q14_ONE    = 16384;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] SHIFT_MAX   = 34'sh1FFFFFFFF;
	localparam logic signed [33:0] SHIFT_MIN   = -34'sh1FFFFFFFF - 34'sd1;

	// floor(2^31 / 36000): quotient estimate is exact or one low for
	// remainders below 2^27
	localparam logic signed [16:0] ANGLE_RECIP = 17'sd59652;
	localparam int                 RECIP_SHIFT = 31;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULX,
		S_MULY,
		S_PITCH,
		S_QUOT,
		S_RSUB,
		S_RFIX,
		S_YAWFIX,
		S_CINIT,
		S_CITER,
		S_CDONE,
		S_PROD,
		S_OUT
	} state_t;

	typedef enum logic {
		REG_SENSITIVITY = 1'b0,
		REG_PITCH_LIMIT = 1'b1
	} reg_idx_t;

	// product schedule: last step index of the multiply sequence
	localparam logic [3:0] OP_LAST = 4'd13;

	// atan(2^-i) in 0.01 degree * 2^16
	function automatic logic signed [32:0] atan_of(input logic [4:0] i);
		logic signed [32:0] v;
		case (i)
			5'd0:  v = 33'sd294912000;
			5'd1:  v = 33'sd174096719;
			5'd2:  v = 33'sd91987925;
			5'd3:  v = 33'sd46694507;
			5'd4:  v = 33'sd23437865;
			5'd5:  v = 33'sd11730358;
			5'd6:  v = 33'sd5866610;
			5'd7:  v = 33'sd2933484;
			5'd8:  v = 33'sd1466764;
			5'd9:  v = 33'sd733385;
			5'd10: v = 33'sd366693;
			5'd11: v = 33'sd183346;
			5'd12: v = 33'sd91673;
			5'd13: v = 33'sd45837;
			5'd14: v = 33'sd22918;
			5'd15: v = 33'sd11459;
			5'd16: v = 33'sd5730;
			5'd17: v = 33'sd2865;
			5'd18: v = 33'sd1432;
			5'd19: v = 33'sd716;
			5'd20: v = 33'sd358;
			5'd21: v = 33'sd179;
			5'd22: v = 33'sd90;
			5'd23: v = 33'sd45;
			default: v = 33'sd0;
		endcase
		return v;
	endfunction

	// Q1.14 product: round half away from zero, clamp to +/-1.0
	function automatic logic signed [15:0] q14_round(input logic signed [48:0] p);
		logic signed [48:0] m;
		logic signed [48:0] r;
		m = (p < 0) ? -p : p;
		r = (m + 49'sd8192) >>> 14;
		if (p < 0)
			r = -r;
		if (r > 49'sd16384)
			r = 49'sd16384;
		else if (r < -49'sd16384)
			r = -49'sd16384;
		return r[15:0];
	endfunction

	// CORDIC output Q2.30 -> Q1.14, optional negation, clamp
	function automatic logic signed [15:0] cordic_out(input logic signed [33:0] v,
		input logic neg);
		logic signed [33:0] m;
		logic signed [33:0] r;
		m = (v < 0) ? -v : v;
		r = (m + 34'sd32768) >>> 16;
		if ((v < 0) != neg)
			r = -r;
		if (r > 34'sd16384)
			r = 34'sd16384;
		else if (r < -34'sd16384)
			r = -34'sd16384;
		return r[15:0];
	endfunction

	// translation: negate dot product, round to Q16.16, saturate to 34 bits
	function automatic logic signed [33:0] shift_round(input logic signed [49:0] d);
		logic signed [49:0] m;
		logic signed [49:0] r;
		m = (d < 0) ? -d : d;
		r = (m + 50'sd8192) >>> 14;
		if (d > 0)
			r = -r;
		if (r > 50'(SHIFT_MAX))
			r = 50'(SHIFT_MAX);
		else if (r < 50'(SHIFT_MIN))
			r = 50'(SHIFT_MIN);
		return r[33:0];
	endfunction

endpackage

`default_nettype wire

[hdl/mouse_look_view_matrix_top.sv]
// ----------------------------------------------------------------------------
// mouse_look_view_matrix_top
// First-person camera: pointer motion updates yaw and pitch, and a look-at
// view matrix (side, up, back rows and translation) is produced per request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* carries one pointer event per request: pointer
//   position and camera position. Master stream m_axis_* returns one view
//   matrix per event. The cfg_* write port sets sensitivity (index 0) and
//   pitch limit (index 1); write only while no event is in flight.
//   One multiplier (17 x 32) and one CORDIC stage are reused, in this order:
//   scaling, yaw remainder (reciprocal multiply, back-multiply, one
//   correction), yaw wrap, sine/cosine for yaw and then for pitch,
//   products, and the load of the output register. Events do not overlap:
//   a new event is taken only after the last one has left the sequencer;
//   s_axis_tready is high only
//   while the sequencer is idle.
//   A finished matrix waits in the output register; the next event is taken
//   while it waits, and the sequencer holds its result until the register
//   drains if the receiver still stalls.
//   Reset clears yaw, pitch and the last pointer position to zero and loads
//   sensitivity 10 and pitch limit 8999.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mouse_look_view_matrix_top
	import mlvm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration writes
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [13:0]  cfg_data,
	// pointer events
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// mouse_x, mouse_y, eye_x, eye_y, eye_z
	input  wire logic [127:0] s_axis_tdata,
	// view matrices
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// side_x, side_y, side_z, up_x, up_y, up_z, back_x, back_y, back_z,
	// shift_x, shift_y, shift_z, 2 pad bits
	output logic [247:0]      m_axis_tdata
);

	state_t state_q, state_d;

	logic [9:0]  sens_q;
	logic [13:0] plim_q;

	logic signed [15:0] last_px_q, last_py_q;
	logic [15:0]        yaw_q;
	logic signed [14:0] pitch_q;

	logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
	logic signed [16:0] dx_q, dy_q;

	logic signed [16:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [48:0] prod_q;

	logic [27:0] rem_q;
	logic        vneg_q;

	logic signed [33:0] cx_q, cyr_q;
	logic signed [32:0] z_q;
	logic [4:0]         step_q;
	logic               fold_q;
	logic               pass_q;

	logic signed [15:0] cosy_q, siny_q, cosp_q, sinp_q;
	logic signed [15:0] upx_q, upy_q, bkx_q, bky_q;
	logic signed [49:0] acc_q;
	logic signed [33:0] shx_q, shy_q, shz_q;
	logic [3:0]         op_q;

	logic         m_tvalid_q;
	logic [247:0] m_tdata_q;

	logic signed [16:0] dx_new, dy_new;
	logic signed [28:0] yaw_sum, pitch_sum, lim;
	logic signed [16:0] ang_raw, ang_wrap, ang_fold;
	logic               ang_neg;
	logic signed [33:0] x_sh, y_sh;
	logic signed [15:0] q_val;
	logic               out_free;

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign out_free      = !m_tvalid_q || m_axis_tready;

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = S_MULX;
			end
			S_MULX:   state_d = S_MULY;
			S_MULY:   state_d = S_PITCH;
			S_PITCH:  state_d = S_QUOT;
			S_QUOT:   state_d = S_RSUB;
			S_RSUB:   state_d = S_RFIX;
			S_RFIX:   state_d = S_YAWFIX;
			S_YAWFIX: state_d = S_CINIT;
			S_CINIT:  state_d = S_CITER;
			S_CITER: begin
				if (step_q == 5'(CORDIC_STEPS - 1))
					state_d = S_CDONE;
			end
			S_CDONE:  state_d = pass_q ? S_PROD : S_CINIT;
			S_PROD: begin
				if (op_q == OP_LAST)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// ---- shared multiplier operand select ----
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULX: begin
				mul_a = dx_q;
				mul_b = {22'd0, sens_q};
			end
			S_MULY: begin
				mul_a = dy_q;
				mul_b = {22'd0, sens_q};
			end
			// yaw quotient estimate: remainder times reciprocal
			S_PITCH: begin
				mul_a = ANGLE_RECIP;
				mul_b = {4'd0, rem_q};
			end
			// quotient back to a multiple of a full turn
			S_QUOT: begin
				mul_a = {5'd0, prod_q[RECIP_SHIFT +: 12]};
				mul_b = 32'(ANGLE_FULL);
			end
			S_PROD: begin
				case (op_q)
					4'd0:  begin mul_a = 17'(cosy_q); mul_b = 32'(sinp_q); end
					4'd1:  begin mul_a = 17'(siny_q); mul_b = 32'(sinp_q); end
					4'd2:  begin mul_a = 17'(cosy_q); mul_b = 32'(cosp_q); end
					4'd3:  begin mul_a = 17'(siny_q); mul_b = 32'(cosp_q); end
					4'd4:  begin mul_a = -17'(siny_q); mul_b = eye_x_q; end
					4'd5:  begin mul_a = -17'(cosy_q); mul_b = eye_y_q; end
					4'd6:  begin mul_a = 17'(upx_q); mul_b = eye_x_q; end
					4'd7:  begin mul_a = 17'(upy_q); mul_b = eye_y_q; end
					4'd8:  begin mul_a = 17'(cosp_q); mul_b = eye_z_q; end
					4'd9:  begin mul_a = 17'(bkx_q); mul_b = eye_x_q; end
					4'd10: begin mul_a = 17'(bky_q); mul_b = eye_y_q; end
					4'd11: begin mul_a = 17'(sinp_q); mul_b = eye_z_q; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---- datapath helpers ----
	always_comb begin
		dx_new    = 17'(signed'(s_axis_tdata[15:0])) - 17'(last_px_q);
		dy_new    = 17'(signed'(s_axis_tdata[31:16])) - 17'(last_py_q);
		yaw_sum   = signed'({13'd0, yaw_q}) + prod_q[28:0];
		pitch_sum = 29'(pitch_q) + prod_q[28:0];
		lim       = (plim_q > 14'(PITCH_MAX)) ? 29'(PITCH_MAX) : signed'({15'd0, plim_q});
		ang_raw   = pass_q ? 17'(pitch_q) : signed'({1'b0, yaw_q});
		ang_wrap  = (ang_raw > 17'(ANGLE_HALF)) ? ang_raw - 17'(ANGLE_FULL) : ang_raw;
		ang_neg   = 1'b0;
		ang_fold  = ang_wrap;
		if (ang_wrap > 17'(ANGLE_QTR)) begin
			ang_fold = ang_wrap - 17'(ANGLE_HALF);
			ang_neg  = 1'b1;
		end else if (ang_wrap < -17'(ANGLE_QTR)) begin
			ang_fold = ang_wrap + 17'(ANGLE_HALF);
			ang_neg  = 1'b1;
		end
		x_sh  = cx_q >>> step_q;
		y_sh  = cyr_q >>> step_q;
		q_val = q14_round(prod_q);
	end

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= 10'd10;
			plim_q <= 14'(PITCH_MAX);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSITIVITY: sens_q <= cfg_data[9:0];
				REG_PITCH_LIMIT: plim_q <= cfg_data;
				default:         sens_q <= sens_q;
			endcase
		end
	end

	// ---- camera state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_px_q <= '0;
			last_py_q <= '0;
			yaw_q     <= '0;
			pitch_q   <= '0;
		end else begin
			if (state_q == S_IDLE && s_axis_tvalid) begin
				last_px_q <= s_axis_tdata[15:0];
				last_py_q <= s_axis_tdata[31:16];
			end
			if (state_q == S_PITCH) begin
				if (pitch_sum > lim)
					pitch_q <= lim[14:0];
				else if (pitch_sum < -lim)
					pitch_q <= 15'(-lim);
				else
					pitch_q <= pitch_sum[14:0];
			end
			if (state_q == S_YAWFIX)
				yaw_q <= (vneg_q && rem_q != 28'd0) ? 16'(28'(ANGLE_FULL) - rem_q)
					: rem_q[15:0];
		end
	end

	// ---- arithmetic datapath (payload, no reset) ----
	always_ff @(posedge clk) begin
		prod_q <= 49'(mul_a) * 49'(mul_b);
		case (state_q)
			S_IDLE: begin
				eye_x_q <= s_axis_tdata[63:32];
				eye_y_q <= s_axis_tdata[95:64];
				eye_z_q <= s_axis_tdata[127:96];
				dx_q    <= dx_new;
				dy_q    <= dy_new;
			end
			S_MULY: begin
				vneg_q <= yaw_sum[28];
				rem_q  <= yaw_sum[28] ? 28'(-yaw_sum) : yaw_sum[27:0];
			end
			// remainder against the estimated quotient, then one correction
			S_RSUB: rem_q <= rem_q - prod_q[27:0];
			S_RFIX: begin
				if (rem_q >= 28'(ANGLE_FULL))
					rem_q <= rem_q - 28'(ANGLE_FULL);
			end
			S_YAWFIX: pass_q <= 1'b0;
			S_CINIT: begin
				cx_q   <= CORDIC_GAIN;
				cyr_q  <= '0;
				z_q    <= 33'(ang_fold) <<< 16;
				fold_q <= ang_neg;
				step_q <= '0;
			end
			S_CITER: begin
				if (!z_q[32]) begin
					cx_q  <= cx_q - y_sh;
					cyr_q <= cyr_q + x_sh;
					z_q   <= z_q - atan_of(step_q);
				end else begin
					cx_q  <= cx_q + y_sh;
					cyr_q <= cyr_q - x_sh;
					z_q   <= z_q + atan_of(step_q);
				end
				step_q <= step_q + 5'd1;
			end
			S_CDONE: begin
				if (pass_q) begin
					cosp_q <= cordic_out(cx_q, fold_q);
					sinp_q <= cordic_out(cyr_q, fold_q);
				end else begin
					cosy_q <= cordic_out(cx_q, fold_q);
					siny_q <= cordic_out(cyr_q, fold_q);
				end
				pass_q <= 1'b1;
				op_q   <= '0;
			end
			S_PROD: begin
				// consume the registered product of the previous step
				case (op_q)
					4'd1:  upx_q <= q_val;
					4'd2:  upy_q <= -q_val;
					4'd3:  bkx_q <= -q_val;
					4'd4:  bky_q <= q_val;
					4'd5:  acc_q <= 50'(prod_q);
					4'd6:  acc_q <= acc_q + 50'(prod_q);
					4'd7: begin
						shx_q <= shift_round(acc_q);
						acc_q <= 50'(prod_q);
					end
					4'd8:  acc_q <= acc_q + 50'(prod_q);
					4'd9:  acc_q <= acc_q + 50'(prod_q);
					4'd10: begin
						shy_q <= shift_round(acc_q);
						acc_q <= 50'(prod_q);
					end
					4'd11: acc_q <= acc_q + 50'(prod_q);
					4'd12: acc_q <= acc_q + 50'(prod_q);
					4'd13: shz_q <= shift_round(acc_q);
					default: acc_q <= acc_q;
				endcase
				op_q <= op_q + 4'd1;
			end
			default: acc_q <= acc_q;
		endcase
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == S_OUT && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_axis_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free)
			m_tdata_q <= {2'b00, shz_q, shy_q, shx_q, sinp_q, bky_q, bkx_q,
				cosp_q, upy_q, upx_q, 16'd0, -cosy_q, -siny_q};
	end

	// ---- checks ----
	`ASSERT_AT(a_yaw_range, clk, arst_n, yaw_q < 16'(ANGLE_FULL), "yaw out of range")
	`ASSERT_AT(a_pitch_range, clk, arst_n,
		(pitch_q <= 15'(PITCH_MAX)) && (pitch_q >= -15'(PITCH_MAX)), "pitch out of range")
	`ASSERT_AT(a_out_load, clk, arst_n,
		(state_q == S_OUT && out_free) |=> m_tvalid_q, "result not presented")
	`ASSERT_NEVER(a_busy_ready, clk, arst_n,
		s_axis_tready && state_q != S_IDLE, "request taken while busy")

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the mouse-look view matrix block against an in-bench predictor of
// yaw/pitch update, CORDIC trig, Q1.14 products and the translation column.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import mlvm_pkg::*;

	typedef struct packed {
		logic signed [31:0] eye_z;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_x;
		logic signed [15:0] mouse_y;
		logic signed [15:0] mouse_x;
	} event_t;

	typedef struct {
		logic signed [15:0] side[3];
		logic signed [15:0] upv[3];
		logic signed [15:0] back[3];
		logic signed [33:0] shift[3];
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [13:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [247:0] m_axis_tdata;

	mouse_look_view_matrix_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	// predictor state
	longint sens_q = 10, plim_q = 8999;
	longint last_x = 0, last_y = 0, yaw_q = 0, pitch_q = 0;

	event_t pending_events[$];
	matrix_t expected_matrices[$];
	int errors = 0;
	int matrices_seen = 0;
	longint cycles = 0;

	function automatic longint rnd_away(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sra(longint v, int s);
		return v < 0 ? ~((~v) >> s) : (v >> s);
	endfunction

	// rotation CORDIC on an angle in 0.01 degree
	task automatic sin_cos(input longint ang, output longint c, output longint s);
		longint x, y, z, t;
		longint atan_tab[24] = '{294912000, 174096719, 91987925, 46694507, 23437865,
			11730358, 5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
			22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		bit flip;
		flip = 0;
		x = 652032874;
		y = 0;
		if (ang > 18000) ang -= 36000;
		if (ang < -18000) ang += 36000;
		if (ang > 9000) begin
			ang -= 18000; flip = 1;
		end else if (ang < -9000) begin
			ang += 18000; flip = 1;
		end
		z = ang * 65536;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				t = x - sra(y, i); y = y + sra(x, i); z -= atan_tab[i];
			end else begin
				t = x + sra(y, i); y = y - sra(x, i); z += atan_tab[i];
			end
			x = t;
		end
		x = rnd_away(x, 16);
		y = rnd_away(y, 16);
		if (flip) begin
			x = -x; y = -y;
		end
		c = sat(x, -16384, 16384);
		s = sat(y, -16384, 16384);
	endtask

	function automatic longint q14_mul(longint a, longint b);
		return sat(rnd_away(a * b, 14), -16384, 16384);
	endfunction

	function automatic longint translation(longint r[3], longint e[3]);
		longint d;
		d = r[0] * e[0] + r[1] * e[1] + r[2] * e[2];
		return sat(rnd_away(-d, 14), -64'sd8589934592, 64'sd8589934591);
	endfunction

	task automatic predict_view(input event_t ev);
		longint dx, dy, yaw, pitch, lim, cy, sy, cp, sp;
		longint sd[3], uv[3], bk[3], eye[3];
		matrix_t m;
		dx = longint'(ev.mouse_x) - last_x;
		dy = longint'(ev.mouse_y) - last_y;
		yaw = (yaw_q + dx * sens_q) % 36000;
		if (yaw < 0) yaw += 36000;
		lim = plim_q > 8999 ? 8999 : plim_q;
		pitch = sat(pitch_q + dy * sens_q, -lim, lim);
		yaw_q = yaw;
		pitch_q = pitch;
		last_x = longint'(ev.mouse_x);
		last_y = longint'(ev.mouse_y);
		sin_cos(yaw, cy, sy);
		sin_cos(pitch, cp, sp);
		sd = '{-sy, -cy, 0};
		uv = '{q14_mul(cy, sp), -q14_mul(sy, sp), cp};
		bk = '{-q14_mul(cy, cp), q14_mul(sy, cp), sp};
		eye = '{longint'(ev.eye_x), longint'(ev.eye_y), longint'(ev.eye_z)};
		for (int k = 0; k < 3; k++) begin
			m.side[k] = 16'(sd[k]);
			m.upv[k] = 16'(uv[k]);
			m.back[k] = 16'(bk[k]);
		end
		m.shift[0] = 34'(translation(sd, eye));
		m.shift[1] = 34'(translation(uv, eye));
		m.shift[2] = 34'(translation(bk, eye));
		expected_matrices.push_back(m);
	endtask

	// request driver
	int send_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_view(event_t'(s_axis_tdata));
				void'(pending_events.pop_front());
				send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
				if (send_gap == 0 && pending_events.size() != 0) begin
					s_axis_tdata <= pending_events[0];
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end else if (!s_axis_tvalid) begin
				if (send_gap > 0)
					send_gap = send_gap - 1;
				else if (pending_events.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_events[0];
				end
			end
		end
	end

	// result monitor and receiver stall
	int recv_gap = 0;
	always @(posedge clk) begin
		matrix_t exp_m;
		logic [247:0] d;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				d = m_axis_tdata;
				matrices_seen++;
				if (expected_matrices.size() == 0) begin
					$error("matrix with none expected");
					errors++;
				end else begin
					exp_m = expected_matrices.pop_front();
					for (int k = 0; k < 3; k++) begin
						if (d[16*k +: 16] !== exp_m.side[k]) begin
							$error("side[%0d] exp %0d got %0d", k, exp_m.side[k],
								$signed(d[16*k +: 16]));
							errors++;
						end
						if (d[48 + 16*k +: 16] !== exp_m.upv[k]) begin
							$error("up[%0d] exp %0d got %0d", k, exp_m.upv[k],
								$signed(d[48 + 16*k +: 16]));
							errors++;
						end
						if (d[96 + 16*k +: 16] !== exp_m.back[k]) begin
							$error("back[%0d] exp %0d got %0d", k, exp_m.back[k],
								$signed(d[96 + 16*k +: 16]));
							errors++;
						end
						if (d[144 + 34*k +: 34] !== exp_m.shift[k]) begin
							$error("shift[%0d] exp %0d got %0d", k, exp_m.shift[k],
								$signed(d[144 + 34*k +: 34]));
							errors++;
						end
					end
				end
				recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
				if (recv_gap != 0)
					m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap = recv_gap - 1;
				if (recv_gap == 0)
					m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic event_t rand_event(bit wide);
		event_t ev;
		if (wide) begin
			ev.mouse_x = 16'($urandom);
			ev.mouse_y = 16'($urandom);
		end else begin
			ev.mouse_x = 16'(last_x + longint'($urandom_range(0, 400)) - 200);
			ev.mouse_y = 16'(last_y + longint'($urandom_range(0, 400)) - 200);
		end
		ev.eye_x = $urandom;
		ev.eye_y = $urandom;
		ev.eye_z = $urandom;
		return ev;
	endfunction

	task automatic drain();
		while (pending_events.size() != 0 || expected_matrices.size() != 0 ||
			s_axis_tvalid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [13:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SENSITIVITY)
			sens_q = longint'(val & 14'h3FF);
		else
			plim_q = longint'(val);
	endtask

	// stimulus phases
	initial begin
		event_t ev;
		logic signed [15:0] mx[6];
		longint save_x, save_y;
		mx = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh0000, -16'sh0001, 16'sh0001};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed: pointer extremes, eye extremes, first event from origin
		for (int i = 0; i < 6; i++) begin
			ev.mouse_x = mx[i];
			ev.mouse_y = mx[5 - i];
			ev.eye_x = (i & 1) ? 32'sh7FFFFFFF : -32'sh80000000;
			ev.eye_y = (i & 2) ? -32'sh80000000 : 32'sh7FFFFFFF;
			ev.eye_z = i == 0 ? 32'sh0 : -32'sh80000000;
			pending_events.push_back(ev);
		end
		drain();
		// extreme settings: max and zero sensitivity, pitch limits above range and zero
		write_reg(REG_SENSITIVITY, 14'h3FF);
		write_reg(REG_PITCH_LIMIT, 14'h3FFF);
		for (int i = 0; i < 8; i++) pending_events.push_back(rand_event(1));
		drain();
		write_reg(REG_PITCH_LIMIT, 14'd0);
		write_reg(REG_SENSITIVITY, 14'd0);
		for (int i = 0; i < 4; i++) pending_events.push_back(rand_event(1));
		drain();
		// random phases under several settings
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_SENSITIVITY, 14'($urandom_range(0, 1023)));
			write_reg(REG_PITCH_LIMIT, ph == 4 ? 14'd8999 : 14'($urandom_range(0, 16383)));
			// the walk moves the pointer; keep the predictor's copy intact
			save_x = last_x;
			save_y = last_y;
			for (int i = 0; i < 200; i++) begin
				ev = rand_event($urandom_range(0, 4) == 0);
				last_x = longint'(ev.mouse_x);
				last_y = longint'(ev.mouse_y);
				pending_events.push_back(ev);
			end
			last_x = save_x;
			last_y = save_y;
			wait (pending_events.size() == 0);
			drain();
		end
		$display("Covered %0d view matrices over several register settings,", matrices_seen);
		$display("pointer and eye extremes, pitch clamping and yaw wrap.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/mlvm_pkg.sv
hdl/mouse_look_view_matrix_top.sv
verif/tb.sv
